### src/assert_macros.svh
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define LSE_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");

// condition must never be true outside reset
`define LSE_ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen");

`else

`define LSE_ASSERT(lbl, clk, rstn, prop)
`define LSE_ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

### src/lse_pkg.sv
// shared types and constants of the led symbol pulse encoder
`timescale 1ns / 1ps
package lse_pkg;

    localparam int TICK_W   = 16;
    localparam int SYM_W    = 8;
    localparam int WORD_W   = 24;
    localparam int BIT_IDX_W = 5;
    localparam int CFG_IDX_W = 3;
    localparam int OUT_DATA_W = 24;

    localparam logic [SYM_W-1:0] SYM_BLUE  = 8'h42;
    localparam logic [SYM_W-1:0] SYM_GREEN = 8'h47;
    localparam logic [SYM_W-1:0] SYM_RED   = 8'h52;

    localparam logic [WORD_W-1:0] WORD_BLUE  = 24'h0000FF;
    localparam logic [WORD_W-1:0] WORD_GREEN = 24'hFF0000;
    localparam logic [WORD_W-1:0] WORD_RED   = 24'h00FF00;

    localparam logic [BIT_IDX_W-1:0] LAST_BIT_IDX = 5'd23;

    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LATCH_LOW  = 3'd4;

    localparam logic [TICK_W-1:0] RST_ZERO_HIGH = 16'd35;
    localparam logic [TICK_W-1:0] RST_ZERO_LOW  = 16'd80;
    localparam logic [TICK_W-1:0] RST_ONE_HIGH  = 16'd70;
    localparam logic [TICK_W-1:0] RST_ONE_LOW   = 16'd60;
    localparam logic [TICK_W-1:0] RST_LATCH_LOW = 16'd5000;

    typedef struct packed {
        logic [TICK_W-1:0] zero_high;
        logic [TICK_W-1:0] zero_low;
        logic [TICK_W-1:0] one_high;
        logic [TICK_W-1:0] one_low;
        logic [TICK_W-1:0] latch_low;
    } timing_t;

    // one queued job for the segment generator
    typedef struct packed {
        logic              start;
        logic              has_word;
        logic [WORD_W-1:0] word;
    } cmd_t;

endpackage

### src/led_symbol_pulse_encoder.sv
// top level of the led symbol pulse encoder with its timing registers
`timescale 1ns / 1ps
// Each accepted colour symbol ('B', 'G', 'R') becomes 48 line segments, a high
// then a low part for each of 24 bits sent msb first; with tuser (frame start)
// set a low latch segment comes first, making 49. Another symbol gives only
// the latch segment, or nothing without frame start. Segments leave one per
// cycle through the output register while the sink is ready; a two-job queue
// behind the input lets the next symbols be taken while the current one is
// still being sent. The last segment of each symbol carries tlast. Timing
// registers are written on the cfg port (always ready) and should change only
// while the block is idle.
module led_symbol_pulse_encoder
    import lse_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [SYM_W-1:0]      s_axis_tdata,   // [7:0] symbol
    input  logic                  s_axis_tuser,   // [0] frame_start
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [0] line_level, [16:1] duration_ticks
    output logic                  m_axis_tlast,   // last_segment
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [TICK_W-1:0]     cfg_data
);

    timing_t timing_reg, timing_next;
    logic    cfg_write;

    logic cmd_push;
    cmd_t cmd_in;
    logic cmd_push_ready;
    logic cmd_pop;
    cmd_t cmd_out;
    logic cmd_valid;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb begin
        timing_next = timing_reg;
        if (cfg_write) begin
            unique case (cfg_index)
                CFG_ZERO_HIGH: timing_next.zero_high = cfg_data;
                CFG_ZERO_LOW:  timing_next.zero_low  = cfg_data;
                CFG_ONE_HIGH:  timing_next.one_high  = cfg_data;
                CFG_ONE_LOW:   timing_next.one_low   = cfg_data;
                CFG_LATCH_LOW: timing_next.latch_low = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timing_reg.zero_high <= RST_ZERO_HIGH;
            timing_reg.zero_low  <= RST_ZERO_LOW;
            timing_reg.one_high  <= RST_ONE_HIGH;
            timing_reg.one_low   <= RST_ONE_LOW;
            timing_reg.latch_low <= RST_LATCH_LOW;
        end else begin
            timing_reg <= timing_next;
        end
    end

    lse_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cmd_push      (cmd_push),
        .cmd_data      (cmd_in),
        .cmd_ready     (cmd_push_ready)
    );

    lse_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (cmd_push),
        .push_data  (cmd_in),
        .push_ready (cmd_push_ready),
        .pop        (cmd_pop),
        .pop_data   (cmd_out),
        .pop_valid  (cmd_valid)
    );

    lse_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .timing        (timing_reg),
        .cmd_valid     (cmd_valid),
        .cmd_data      (cmd_out),
        .cmd_pop       (cmd_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

### src/lse_front.sv
// input side: takes symbols and turns them into segment jobs
`timescale 1ns / 1ps
module lse_front
    import lse_pkg::*;
(
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [SYM_W-1:0] s_axis_tdata,   // [7:0] symbol
    input  logic             s_axis_tuser,   // [0] frame_start
    output logic             cmd_push,
    output cmd_t             cmd_data,
    input  logic             cmd_ready
);

    logic accept;

    always_comb begin
        cmd_data.start    = s_axis_tuser;
        cmd_data.has_word = 1'b1;
        unique case (s_axis_tdata)
            SYM_BLUE:  cmd_data.word = WORD_BLUE;
            SYM_GREEN: cmd_data.word = WORD_GREEN;
            SYM_RED:   cmd_data.word = WORD_RED;
            default: begin
                cmd_data.word     = '0;
                cmd_data.has_word = 1'b0;
            end
        endcase
    end

    assign s_axis_tready = cmd_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    // unknown symbol without frame start yields nothing, drop it here
    assign cmd_push      = accept && (cmd_data.start || cmd_data.has_word);

endmodule

### src/lse_fifo.sv
// two-entry job queue between front and back
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lse_fifo
    import lse_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_data,
    output logic push_ready,
    input  logic pop,
    output cmd_t pop_data,
    output logic pop_valid
);

    cmd_t       mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `LSE_ASSERT_NEVER(a_no_overfill, aclk, aresetn, count_reg == 2'd3)
    `LSE_ASSERT_NEVER(a_no_push_full, aclk, aresetn, push && count_reg == 2'd2)
    `LSE_ASSERT_NEVER(a_no_pop_empty, aclk, aresetn, pop && count_reg == 2'd0)

endmodule

### src/lse_back.sv
// output side: walks one job and emits one segment per cycle while the sink is ready
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lse_back
    import lse_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  timing_t               timing,
    input  logic                  cmd_valid,
    input  cmd_t                  cmd_data,
    output logic                  cmd_pop,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // [0] line_level, [16:1] duration_ticks
    output logic                  m_axis_tlast   // last_segment
);

    logic                 busy_reg, busy_next;
    logic                 latch_reg, latch_next;
    logic                 has_word_reg, has_word_next;
    logic [WORD_W-1:0]    word_reg, word_next;
    logic [BIT_IDX_W-1:0] idx_reg, idx_next;
    logic                 phase_reg, phase_next;   // 0 high part, 1 low part

    logic                 out_valid_reg, out_valid_next;
    logic                 out_level_reg, out_level_next;
    logic [TICK_W-1:0]    out_ticks_reg, out_ticks_next;
    logic                 out_last_reg, out_last_next;

    logic              advance;
    logic              finishing;
    logic              load;
    logic              seg_level;
    logic [TICK_W-1:0] seg_ticks;
    logic              seg_last;
    logic              cur_bit;

    assign advance   = busy_reg && (!out_valid_reg || m_axis_tready);
    assign cur_bit   = word_reg[WORD_W-1];

    always_comb begin
        if (latch_reg) begin
            seg_level = 1'b0;
            seg_ticks = timing.latch_low;
            seg_last  = !has_word_reg;
        end else if (!phase_reg) begin
            seg_level = 1'b1;
            seg_ticks = cur_bit ? timing.one_high : timing.zero_high;
            seg_last  = 1'b0;
        end else begin
            seg_level = 1'b0;
            seg_ticks = cur_bit ? timing.one_low : timing.zero_low;
            seg_last  = (idx_reg == LAST_BIT_IDX);
        end
    end

    assign finishing = advance && seg_last;
    assign load      = cmd_valid && (!busy_reg || finishing);
    assign cmd_pop   = load;

    always_comb begin
        busy_next     = busy_reg;
        latch_next    = latch_reg;
        has_word_next = has_word_reg;
        word_next     = word_reg;
        idx_next      = idx_reg;
        phase_next    = phase_reg;

        if (advance) begin
            if (latch_reg) begin
                latch_next = 1'b0;
            end else if (!phase_reg) begin
                phase_next = 1'b1;
            end else begin
                phase_next = 1'b0;
                word_next  = {word_reg[WORD_W-2:0], 1'b0};
                idx_next   = idx_reg + BIT_IDX_W'(1);
            end
            if (seg_last) begin
                busy_next = 1'b0;
            end
        end

        if (load) begin
            busy_next     = 1'b1;
            latch_next    = cmd_data.start;
            has_word_next = cmd_data.has_word;
            word_next     = cmd_data.word;
            idx_next      = '0;
            phase_next    = 1'b0;
        end
    end

    // output register doubles as the skid stage toward the sink
    always_comb begin
        out_valid_next = out_valid_reg;
        out_level_next = out_level_reg;
        out_ticks_next = out_ticks_reg;
        out_last_next  = out_last_reg;
        if (!out_valid_reg || m_axis_tready) begin
            out_valid_next = advance;
            out_level_next = seg_level;
            out_ticks_next = seg_ticks;
            out_last_next  = seg_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            latch_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            latch_reg     <= latch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        has_word_reg  <= has_word_next;
        word_reg      <= word_next;
        idx_reg       <= idx_next;
        phase_reg     <= phase_next;
        out_level_reg <= out_level_next;
        out_ticks_reg <= out_ticks_next;
        out_last_reg  <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - TICK_W - 1){1'b0}}, out_ticks_reg, out_level_reg};
    assign m_axis_tlast  = out_last_reg;

    `LSE_ASSERT_NEVER(a_idx_range, aclk, aresetn, busy_reg && idx_reg > LAST_BIT_IDX)
    `LSE_ASSERT_NEVER(a_latch_needs_busy, aclk, aresetn, latch_reg && !busy_reg)
    `LSE_ASSERT(a_last_ends_job, aclk, aresetn, (finishing && !load) |=> !busy_reg)

endmodule
